/* src/rgb2yuv_pkg.sv */
// Package with shared widths, coefficients and the queue entry type of the RGB to YUV converter.
`timescale 1ns / 1ps
`default_nettype none
package rgb2yuv_pkg;

	// Frame limits and coefficient precision
	localparam int MAX_WIDTH      = 4096;
	localparam int MAX_HEIGHT     = 4096;
	localparam int COEF_FRAC_BITS = 16;

	// Register port
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_HEIGHT = CFG_IDX_W'(1);

	// Counter and index widths
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int EW_W   = $clog2(MAX_WIDTH + 1);
	localparam int EH_W   = $clog2(MAX_HEIGHT + 1);
	localparam int LIDX_W = 24;
	localparam int CIDX_W = 22;
	localparam int CMUL_W = (ROW_W - 1) + (EW_W - 1);

	// Arithmetic widths
	localparam int LPROD_W = COEF_FRAC_BITS + 8;
	localparam int LSUM_W  = COEF_FRAC_BITS + 10;
	localparam int CPROD_W = COEF_FRAC_BITS + 10;
	localparam int CSUM_W  = COEF_FRAC_BITS + 11;

	// Luma coefficients are floored, chroma coefficients are rounded
	localparam logic [COEF_FRAC_BITS-1:0] KR_C =
		COEF_FRAC_BITS'((299 << COEF_FRAC_BITS) / 1000);
	localparam logic [COEF_FRAC_BITS-1:0] KG_C =
		COEF_FRAC_BITS'((587 << COEF_FRAC_BITS) / 1000);
	localparam logic [COEF_FRAC_BITS-1:0] KB_C =
		COEF_FRAC_BITS'((114 << COEF_FRAC_BITS) / 1000);
	localparam logic [COEF_FRAC_BITS-1:0] KU_C =
		COEF_FRAC_BITS'(((565 << COEF_FRAC_BITS) + 500) / 1000);
	localparam logic [COEF_FRAC_BITS-1:0] KV_C =
		COEF_FRAC_BITS'(((713 << COEF_FRAC_BITS) + 500) / 1000);
	localparam int CHROMA_BIAS = 128 << COEF_FRAC_BITS;

	// Queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic [LIDX_W-1:0] luma_index;
		logic              chroma_valid;
		logic              frame_end;
		logic [ROW_W-2:0]  crow;
		logic [EW_W-2:0]   chalf;
		logic [COL_W-2:0]  ccol;
	} pixel_entry_t;

endpackage
`default_nettype wire

/* src/rgb2yuv_if.sv */
// Channel interfaces of the RGB to YUV converter: pixel input, YUV output, register writes.
`timescale 1ns / 1ps
`default_nettype none
interface rgb2yuv_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgb2yuv_yuv_if import rgb2yuv_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [7:0]        luma;
	logic [LIDX_W-1:0] luma_index;
	logic              chroma_valid;
	logic [7:0]        chroma_u;
	logic [7:0]        chroma_v;
	logic [CIDX_W-1:0] chroma_index;
	logic              frame_end;

	modport source (output valid, luma, luma_index, chroma_valid, chroma_u, chroma_v,
		chroma_index, frame_end, input ready);
	modport sink   (input valid, luma, luma_index, chroma_valid, chroma_u, chroma_v,
		chroma_index, frame_end, output ready);
endinterface

interface rgb2yuv_cfg_if import rgb2yuv_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/rgb2yuv_front.sv */
// Front end: register port, raster counters and per-pixel classification into queue entries.
`timescale 1ns / 1ps
`default_nettype none
module rgb2yuv_front import rgb2yuv_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	rgb2yuv_pix_if.sink       pix,
	rgb2yuv_cfg_if.sink       cfg,
	input  wire logic         queue_full,
	output logic              push,
	output pixel_entry_t      entry
);

	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [LIDX_W-1:0] offset_q;
	logic [EW_W-1:0]   w_eff;
	logic [EH_W-1:0]   h_eff;
	logic              last_col;
	logic              last_row;

	// Accept registers at all times
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(640);
			height_q <= CFG_W'(480);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_IDX_FRAME_WIDTH:  width_q  <= cfg.data;
				CFG_IDX_FRAME_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Clamp sizes: zero acts as one, oversize acts as the maximum
	always_comb begin
		if (width_q == '0)
			w_eff = EW_W'(1);
		else if (32'(width_q) > MAX_WIDTH)
			w_eff = EW_W'(MAX_WIDTH);
		else
			w_eff = EW_W'(width_q);
		if (height_q == '0)
			h_eff = EH_W'(1);
		else if (32'(height_q) > MAX_HEIGHT)
			h_eff = EH_W'(MAX_HEIGHT);
		else
			h_eff = EH_W'(height_q);
	end

	assign last_col = ((EW_W+1)'(col_q) + (EW_W+1)'(1)) >= (EW_W+1)'(w_eff);
	assign last_row = ((EH_W+1)'(row_q) + (EH_W+1)'(1)) >= (EH_W+1)'(h_eff);

	// Take a pixel whenever the queue has room
	assign pix.ready = !queue_full;
	assign push      = pix.valid && !queue_full;

	// Advance raster counters on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			offset_q <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q    <= '0;
					offset_q <= '0;
				end else begin
					row_q    <= row_q + ROW_W'(1);
					offset_q <= offset_q + LIDX_W'(1);
				end
			end else begin
				col_q    <= col_q + COL_W'(1);
				offset_q <= offset_q + LIDX_W'(1);
			end
		end
	end

	// Build the queue entry
	always_comb begin
		entry.red          = pix.red;
		entry.green        = pix.green;
		entry.blue         = pix.blue;
		entry.luma_index   = offset_q;
		entry.chroma_valid = !row_q[0] && !col_q[0];
		entry.frame_end    = last_col && last_row;
		entry.crow         = row_q[ROW_W-1:1];
		entry.chalf        = w_eff[EW_W-1:1];
		entry.ccol         = col_q[COL_W-1:1];
	end

endmodule
`default_nettype wire

/* src/rgb2yuv_queue.sv */
// Short queue of classified pixels between the front and the back end.
`timescale 1ns / 1ps
`default_nettype none
module rgb2yuv_queue import rgb2yuv_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire pixel_entry_t push_entry,
	output logic              full,
	input  wire logic         pop,
	output logic              empty,
	output pixel_entry_t      head
);

	pixel_entry_t       slots_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = count_q == (PTR_W+1)'(FIFO_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slots_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_entry;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (PTR_W+1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (PTR_W+1)'(1);
		end
	end

endmodule
`default_nettype wire

/* src/rgb2yuv_back.sv */
// Back end: four-stage pipeline computing luma, clamped chroma and the chroma plane offset.
`timescale 1ns / 1ps
`default_nettype none
module rgb2yuv_back import rgb2yuv_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         queue_empty,
	input  wire pixel_entry_t head,
	output logic              pop,
	rgb2yuv_yuv_if.source     yuv
);

	function automatic logic [7:0] clamp_chroma(input logic signed [CSUM_W-1:0] s);
		logic [CSUM_W-1:0] q;
		begin
			q = CSUM_W'(s) >> COEF_FRAC_BITS;
			if (s < 0)
				return 8'd0;
			else if (q > CSUM_W'(255))
				return 8'hFF;
			else
				return q[7:0];
		end
	endfunction

	logic                       advance;
	logic                       v1_q, v2_q, v3_q, v4_q;

	logic [LPROD_W-1:0]         pr_s1, pg_s1, pb_s1;
	logic [7:0]                 red_s1, blue_s1;
	logic [LIDX_W-1:0]          lidx_s1;
	logic                       cv_s1, fe_s1;
	logic [CMUL_W-1:0]          cprod_s1;
	logic [COL_W-2:0]           ccol_s1;

	logic [LSUM_W-1:0]          lsum;
	logic [7:0]                 y_c;
	logic [7:0]                 y_s2;
	logic signed [8:0]          du_s2, dv_s2;
	logic [LIDX_W-1:0]          lidx_s2;
	logic                       cv_s2, fe_s2;
	logic [CIDX_W-1:0]          cidx_s2;

	logic signed [CPROD_W-1:0]  pu_s3, pv_s3;
	logic [7:0]                 y_s3;
	logic [LIDX_W-1:0]          lidx_s3;
	logic                       cv_s3, fe_s3;
	logic [CIDX_W-1:0]          cidx_s3;

	logic signed [CSUM_W-1:0]   su, sv;

	logic [7:0]                 luma_s4, u_s4, v_s4;
	logic [LIDX_W-1:0]          lidx_s4;
	logic                       cv_s4, fe_s4;
	logic [CIDX_W-1:0]          cidx_s4;

	// Move the whole pipeline unless the output is held
	assign advance = !v4_q || yuv.ready;
	assign pop     = advance && !queue_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else if (advance) begin
			v1_q <= !queue_empty;
			v2_q <= v1_q;
			v3_q <= v2_q;
			v4_q <= v3_q;
		end
	end

	// Stage 1: luma products and chroma row offset product
	always_ff @(posedge clk) begin
		if (advance) begin
			pr_s1    <= LPROD_W'(head.red)   * LPROD_W'(KR_C);
			pg_s1    <= LPROD_W'(head.green) * LPROD_W'(KG_C);
			pb_s1    <= LPROD_W'(head.blue)  * LPROD_W'(KB_C);
			red_s1   <= head.red;
			blue_s1  <= head.blue;
			lidx_s1  <= head.luma_index;
			cv_s1    <= head.chroma_valid;
			fe_s1    <= head.frame_end;
			cprod_s1 <= CMUL_W'(head.crow) * CMUL_W'(head.chalf);
			ccol_s1  <= head.ccol;
		end
	end

	// Stage 2: luma sum, color differences, chroma offset
	assign lsum = LSUM_W'(pr_s1) + LSUM_W'(pg_s1) + LSUM_W'(pb_s1);
	assign y_c  = lsum[COEF_FRAC_BITS+7:COEF_FRAC_BITS];

	always_ff @(posedge clk) begin
		if (advance) begin
			y_s2    <= y_c;
			du_s2   <= $signed({1'b0, blue_s1}) - $signed({1'b0, y_c});
			dv_s2   <= $signed({1'b0, red_s1})  - $signed({1'b0, y_c});
			lidx_s2 <= lidx_s1;
			cv_s2   <= cv_s1;
			fe_s2   <= fe_s1;
			cidx_s2 <= CIDX_W'((CMUL_W+1)'(cprod_s1) + (CMUL_W+1)'(ccol_s1));
		end
	end

	// Stage 3: chroma products
	always_ff @(posedge clk) begin
		if (advance) begin
			pu_s3   <= CPROD_W'(du_s2) * CPROD_W'($signed({1'b0, KU_C}));
			pv_s3   <= CPROD_W'(dv_s2) * CPROD_W'($signed({1'b0, KV_C}));
			y_s3    <= y_s2;
			lidx_s3 <= lidx_s2;
			cv_s3   <= cv_s2;
			fe_s3   <= fe_s2;
			cidx_s3 <= cidx_s2;
		end
	end

	// Stage 4: bias, clamp, drop chroma on unsampled pixels
	assign su = CSUM_W'(pu_s3) + CSUM_W'(CHROMA_BIAS);
	assign sv = CSUM_W'(pv_s3) + CSUM_W'(CHROMA_BIAS);

	always_ff @(posedge clk) begin
		if (advance) begin
			luma_s4 <= y_s3;
			lidx_s4 <= lidx_s3;
			cv_s4   <= cv_s3;
			fe_s4   <= fe_s3;
			u_s4    <= cv_s3 ? clamp_chroma(su) : 8'd0;
			v_s4    <= cv_s3 ? clamp_chroma(sv) : 8'd0;
			cidx_s4 <= cv_s3 ? cidx_s3 : '0;
		end
	end

	assign yuv.valid        = v4_q;
	assign yuv.luma         = luma_s4;
	assign yuv.luma_index   = lidx_s4;
	assign yuv.chroma_valid = cv_s4;
	assign yuv.chroma_u     = u_s4;
	assign yuv.chroma_v     = v_s4;
	assign yuv.chroma_index = cidx_s4;
	assign yuv.frame_end    = fe_s4;

endmodule
`default_nettype wire

/* src/rgb_to_yuv420_planar_top.sv */
// Top level of the RGB to planar YUV 4:2:0 converter.
//
// Usage:
//   pix carries one RGB pixel per transfer in raster order. yuv returns one
//   result per pixel: luma and its plane offset, and on even rows and even
//   columns point-sampled U and V with their chroma plane offset. frame_end
//   marks the last pixel of a frame; the counters then wrap to zero.
//   cfg writes frame_width (index 0) and frame_height (index 1); write them
//   only while no pixel is in flight. cfg.ready is always high.
// Timing:
//   A transferred pixel enters the queue and then the four-stage back-end
//   pipeline, with one multiplier stage for luma and one for chroma, before it
//   shows on yuv. The block takes one pixel per clock while pix.ready is high.
// Reset:
//   arst_n clears the counters and the queue and loads 640 by 480.
// Stall:
//   While yuv.ready is low the result holds; the four-entry queue between
//   front and back keeps taking pixels until it fills, then pix.ready drops.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_yuv420_planar_top import rgb2yuv_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	rgb2yuv_pix_if.sink   pix,
	rgb2yuv_yuv_if.source yuv,
	rgb2yuv_cfg_if.sink   cfg
);

	logic         push;
	logic         pop;
	logic         queue_full;
	logic         queue_empty;
	pixel_entry_t push_entry;
	pixel_entry_t head;

	rgb2yuv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix),
		.cfg        (cfg),
		.queue_full (queue_full),
		.push       (push),
		.entry      (push_entry)
	);

	rgb2yuv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.empty      (queue_empty),
		.head       (head)
	);

	rgb2yuv_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.head        (head),
		.pop         (pop),
		.yuv         (yuv)
	);

endmodule
`default_nettype wire

/* src/rgb2yuv_checker.sv */
// Port-level assertions on the YUV output of the converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rgb2yuv_checker import rgb2yuv_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [7:0]        luma,
	input wire logic [LIDX_W-1:0] luma_index,
	input wire logic              chroma_valid,
	input wire logic [7:0]        chroma_u,
	input wire logic [7:0]        chroma_v,
	input wire logic [CIDX_W-1:0] chroma_index,
	input wire logic              frame_end
);

	logic              have_prev_q;
	logic              end_seen_q;
	logic [LIDX_W-1:0] last_idx_q;

	// Track the previous output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			end_seen_q  <= 1'b0;
			last_idx_q  <= '0;
		end else if (out_valid && out_ready) begin
			have_prev_q <= 1'b1;
			end_seen_q  <= frame_end;
			last_idx_q  <= luma_index;
		end
	end

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({luma, luma_index, chroma_valid,
			chroma_u, chroma_v, chroma_index, frame_end}))
		else $error("stalled result changed");

	// Unsampled pixels carry zero chroma
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !chroma_valid |-> chroma_u == 8'd0 && chroma_v == 8'd0 &&
			chroma_index == '0)
		else $error("chroma fields not zero on unsampled pixel");

	// A frame restarts at offset zero with a chroma sample
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_seen_q |-> luma_index == '0 && chroma_valid)
		else $error("frame did not restart at the origin");

	// Within a frame the luma offset steps by one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && have_prev_q && !end_seen_q |-> luma_index == last_idx_q + LIDX_W'(1))
		else $error("luma offset skipped or repeated");

endmodule

bind rgb_to_yuv420_planar_top rgb2yuv_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (yuv.valid),
	.out_ready    (yuv.ready),
	.luma         (yuv.luma),
	.luma_index   (yuv.luma_index),
	.chroma_valid (yuv.chroma_valid),
	.chroma_u     (yuv.chroma_u),
	.chroma_v     (yuv.chroma_v),
	.chroma_index (yuv.chroma_index),
	.frame_end    (yuv.frame_end)
);
`default_nettype wire

/* test/tb_top.sv */
// Testbench for the RGB to planar YUV 4:2:0 converter: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
	import rgb2yuv_pkg::*;

	// Predictor constants, Q16
	localparam int unsigned FRAC      = 16;
	localparam int unsigned LUMA_KR   = (299 << FRAC) / 1000;
	localparam int unsigned LUMA_KG   = (587 << FRAC) / 1000;
	localparam int unsigned LUMA_KB   = (114 << FRAC) / 1000;
	localparam int          CHROMA_KU = ((565 << FRAC) + 500) / 1000;
	localparam int          CHROMA_KV = ((713 << FRAC) + 500) / 1000;
	localparam longint      CHROMA_OFFSET = longint'(128) << FRAC;

	// Register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = CFG_IDX_W'(3);

	localparam int QUIET_LIMIT   = 3000;
	localparam int DRAIN_CYCLES  = 16;
	localparam int REPORT_LIMIT  = 100;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct {
		logic [7:0]        luma;
		logic [LIDX_W-1:0] luma_index;
		logic              chroma_valid;
		logic [7:0]        chroma_u;
		logic [7:0]        chroma_v;
		logic [CIDX_W-1:0] chroma_index;
		logic              frame_end;
	} yuv_result_t;

	logic clk = 1'b0;
	logic arst_n;

	rgb2yuv_pix_if pix_ch ();
	rgb2yuv_yuv_if yuv_ch ();
	rgb2yuv_cfg_if cfg_ch ();

	rgb_to_yuv420_planar_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.yuv    (yuv_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state: geometry registers and raster counters
	logic [CFG_W-1:0] frame_w_cfg;
	logic [CFG_W-1:0] frame_h_cfg;
	int unsigned      col_pos;
	int unsigned      row_pos;
	int unsigned      pix_offset;

	yuv_result_t expected_yuv[$];

	// Traffic shaping
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;

	// Run statistics
	int mismatch_count;
	int pixels_sent;
	int results_checked;
	int chroma_seen;
	int frames_seen;
	int geometry_count;
	int reg_writes;

	// Clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned effective_size(logic [CFG_W-1:0] v, int unsigned maxv);
		if (v == '0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	function automatic logic [7:0] chroma_sample(int diff, int coef);
		longint acc;
		acc = longint'(diff) * coef + CHROMA_OFFSET;
		if (acc < 0)
			return 8'd0;
		acc = acc >>> FRAC;
		if (acc > 255)
			return 8'd255;
		return acc[7:0];
	endfunction

	// Work out the result of one pixel and advance the raster counters
	function automatic yuv_result_t convert_pixel(rgb_t px);
		yuv_result_t res;
		int unsigned w;
		int unsigned h;
		int unsigned y;
		int unsigned ci;
		bit last_col;
		bit last_row;
		w = effective_size(frame_w_cfg, MAX_WIDTH);
		h = effective_size(frame_h_cfg, MAX_HEIGHT);
		y = (LUMA_KR * px.red + LUMA_KG * px.green + LUMA_KB * px.blue) >> FRAC;
		if (y > 255)
			y = 255;
		last_col = (col_pos + 1) >= w;
		last_row = (row_pos + 1) >= h;
		res.luma         = y[7:0];
		res.luma_index   = pix_offset[LIDX_W-1:0];
		res.chroma_valid = !row_pos[0] && !col_pos[0];
		if (res.chroma_valid) begin
			ci = (row_pos / 2) * (w / 2) + col_pos / 2;
			res.chroma_u     = chroma_sample(int'(px.blue) - int'(y), CHROMA_KU);
			res.chroma_v     = chroma_sample(int'(px.red) - int'(y), CHROMA_KV);
			res.chroma_index = ci[CIDX_W-1:0];
		end else begin
			res.chroma_u     = '0;
			res.chroma_v     = '0;
			res.chroma_index = '0;
		end
		res.frame_end = last_col && last_row;
		if (last_col) begin
			col_pos = 0;
			if (last_row) begin
				row_pos    = 0;
				pix_offset = 0;
			end else begin
				row_pos++;
				pix_offset = (pix_offset + 1) & 32'hFF_FFFF;
			end
		end else begin
			col_pos++;
			pix_offset = (pix_offset + 1) & 32'hFF_FFFF;
		end
		return res;
	endfunction

	function automatic rgb_t random_pixel();
		rgb_t px;
		px.red   = $urandom_range(7) == 0 ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom);
		px.green = $urandom_range(7) == 0 ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom);
		px.blue  = $urandom_range(7) == 0 ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom);
		return px;
	endfunction

	function automatic rgb_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		rgb_t px;
		px.red   = r;
		px.green = g;
		px.blue  = b;
		return px;
	endfunction

	// Receiver: random stalls, or a counted hold-off when one is requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			yuv_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			yuv_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t: %s of result %0d expected %0d, got %0d",
					$time, name, results_checked, want, got);
			else if (mismatch_count == REPORT_LIMIT + 1)
				$display("%0t: further mismatch reports suppressed", $time);
		end
	endtask

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		yuv_result_t want;
		if (yuv_ch.valid === 1'b1 && yuv_ch.ready === 1'b1) begin
			if (expected_yuv.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with none expected, luma %0d luma_index %0d",
					$time, yuv_ch.luma, yuv_ch.luma_index);
			end else begin
				want = expected_yuv.pop_front();
				check_field("luma", want.luma, yuv_ch.luma);
				check_field("luma_index", want.luma_index, yuv_ch.luma_index);
				check_field("chroma_valid", want.chroma_valid, yuv_ch.chroma_valid);
				check_field("chroma_u", want.chroma_u, yuv_ch.chroma_u);
				check_field("chroma_v", want.chroma_v, yuv_ch.chroma_v);
				check_field("chroma_index", want.chroma_index, yuv_ch.chroma_index);
				check_field("frame_end", want.frame_end, yuv_ch.frame_end);
				results_checked++;
				chroma_seen += want.chroma_valid;
				frames_seen += want.frame_end;
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) ||
				(yuv_ch.valid === 1'b1 && yuv_ch.ready === 1'b1) ||
				(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: timeout, no transfer in %0d cycles, %0d results outstanding",
			$time, QUIET_LIMIT, expected_yuv.size());
		$display("Mismatches found");
		$finish;
	end

	// Offer one pixel after a random idle gap; predict on transfer
	task automatic send_pixel(rgb_t px);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			pix_ch.valid <= 1'b0;
		end
		@(negedge clk);
		pix_ch.valid <= 1'b1;
		pix_ch.red   <= px.red;
		pix_ch.green <= px.green;
		pix_ch.blue  <= px.blue;
		do @(posedge clk); while (pix_ch.ready !== 1'b1);
		expected_yuv.push_back(convert_pixel(px));
		pixels_sent++;
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic drain_results();
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		while (expected_yuv.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value[CFG_W-1:0];
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (idx)
			CFG_IDX_FRAME_WIDTH:  frame_w_cfg = value[CFG_W-1:0];
			CFG_IDX_FRAME_HEIGHT: frame_h_cfg = value[CFG_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// Write a new frame size while idle; counters carry over
	task automatic set_geometry(int unsigned w, int unsigned h, bit with_spare = 1'b0);
		drain_results();
		write_reg(CFG_IDX_FRAME_WIDTH, w);
		write_reg(CFG_IDX_FRAME_HEIGHT, h);
		if (with_spare) begin
			write_reg(CFG_IDX_SPARE_LO, 1);
			write_reg(CFG_IDX_SPARE_HI, 2);
		end
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		geometry_count++;
	endtask

	// Drop valid so the last pixel is not offered again, then switch the phase
	task automatic set_traffic(int idle_pct, int stall_pct);
		@(negedge clk);
		pix_ch.valid   <= 1'b0;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	// Reset geometry: primaries and extremes at 640 by 480
	task automatic test_reset_geometry();
		send_pixel(make_pixel(8'h00, 8'h00, 8'h00));
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF));
		send_pixel(make_pixel(8'hFF, 8'h00, 8'h00));
		send_pixel(make_pixel(8'h00, 8'hFF, 8'h00));
		send_pixel(make_pixel(8'h00, 8'h00, 8'hFF));
	endtask

	// Odd width: 3 by 3 frame run through a frame end and into the next frame
	task automatic test_odd_width();
		set_geometry(3, 3);
		send_pixel(make_pixel(8'h00, 8'hFF, 8'hFF));
		send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF));
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'h00));
		repeat (7)
			send_pixel(random_pixel());
	endtask

	// Zero size acts as one, oversize acts as the maximum, spare indexes ignored
	task automatic test_size_limits();
		set_geometry(0, 0);
		send_pixel(make_pixel(8'h80, 8'h80, 8'h80));
		send_pixel(make_pixel(8'h00, 8'hFF, 8'h00));
		set_geometry(8191, 8191);
		send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF));
		send_pixel(random_pixel());
		set_geometry(4096, 4096, 1'b1);
		send_pixel(random_pixel());
	endtask

	// Shrink the width from 5 to 2 mid-row; the counters carry over
	task automatic test_resize_mid_frame();
		set_geometry(5, 4);
		repeat (3)
			send_pixel(random_pixel());
		set_geometry(2, 4);
		repeat (2)
			send_pixel(random_pixel());
	endtask

	// Random pixels in chunks, each chunk under a new frame size, mostly small
	task automatic test_random_traffic(int idle_pct, int stall_pct, int count);
		int sent;
		int chunk;
		int sel;
		int unsigned w;
		int unsigned h;
		set_traffic(idle_pct, stall_pct);
		sent = 0;
		while (sent < count) begin
			sel = $urandom_range(9);
			if (sel == 0) begin
				w = $urandom_range(8191);
				h = $urandom_range(3);
			end else if (sel == 1) begin
				w = $urandom_range(3);
				h = $urandom_range(8191);
			end else begin
				w = $urandom_range(9);
				h = $urandom_range(9);
			end
			set_geometry(w, h);
			chunk = $urandom_range(20, 60);
			repeat (chunk)
				send_pixel(random_pixel());
			sent += chunk;
		end
	endtask

	// Tall single-column frame, then full width to push the chroma offset up
	task automatic test_tall_frame();
		set_traffic(0, 0);
		set_geometry(1, 4096);
		repeat (240)
			send_pixel(random_pixel());
		set_geometry(4096, 4096);
		repeat (20)
			send_pixel(random_pixel());
	endtask

	// Hold the receiver off so the queue fills and the input stalls
	task automatic test_backpressure();
		set_traffic(0, 0);
		set_geometry(6, 5);
		repeat (3)
			send_pixel(random_pixel());
		hold_left = 200;
		repeat (40)
			send_pixel(random_pixel());
		// pause the sender until everything is back
		drain_results();
		repeat (12)
			send_pixel(random_pixel());
	endtask

	initial begin
		arst_n         = 1'b0;
		pix_ch.valid   = 1'b0;
		pix_ch.red     = '0;
		pix_ch.green   = '0;
		pix_ch.blue    = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = CFG_IDX_FRAME_WIDTH;
		cfg_ch.data    = '0;
		yuv_ch.ready   = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 0;
		mismatch_count = 0;
		pixels_sent    = 0;
		results_checked = 0;
		chroma_seen    = 0;
		frames_seen    = 0;
		geometry_count = 0;
		reg_writes     = 0;
		frame_w_cfg    = CFG_W'(640);
		frame_h_cfg    = CFG_W'(480);
		col_pos        = 0;
		row_pos        = 0;
		pix_offset     = 0;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_geometry();
		test_odd_width();
		test_size_limits();
		test_resize_mid_frame();
		test_random_traffic(0, 0, 350);
		test_random_traffic(84, 0, 350);
		test_random_traffic(0, 84, 350);
		test_random_traffic(16, 16, 350);
		test_tall_frame();
		test_backpressure();

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d pixels, %0d results, %0d with chroma, %0d frame ends.",
			pixels_sent, results_checked, chroma_seen, frames_seen);
		$display("Frame size changed %0d times with %0d register writes.",
			geometry_count, reg_writes);
		if (mismatch_count == 0 && expected_yuv.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
